[rtl/sric_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sric_pkg
// Request and response types and command codes for the sorted ring index cache.
// ----------------------------------------------------------------------------
package sric_pkg;

    localparam int KEY_W = 64;
    localparam int VAL_W = 64;

    // Command codes
    localparam logic CMD_APPEND = 1'b0;
    localparam logic CMD_SEARCH = 1'b1;

    typedef struct packed {
        logic                    cmd;
        logic signed [KEY_W-1:0] key;
        logic signed [VAL_W-1:0] entry_value;
    } sric_req_t;

    typedef struct packed {
        logic                    found;
        logic signed [VAL_W-1:0] found_value;
    } sric_rsp_t;

endpackage

[rtl/sorted_ring_index_cache_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_ring_index_cache_core
// Ring of DEPTH key/value entries with binary-search lookup.
// ----------------------------------------------------------------------------
// An append request produces no response; the next request can follow in the
// very next cycle. A search request runs a binary search against one
// synchronous RAM that holds key and value side by side. Each probe is an
// address issue followed by a compare of the registered read data; a search
// over a run of n entries makes up to floor(log2(n)) + 1 probes, and a miss
// ends with an issue step that finds the range empty; when the ring has wrapped,
// that step after a miss in the newer run moves the search on to the older
// run. A final done step hands the response to the output register.
// The output register lets a new request enter while a response waits.
// ----------------------------------------------------------------------------
module sorted_ring_index_cache_core #(
    parameter int DEPTH = 256
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  sric_pkg::sric_req_t s_payload,
    output logic                m_valid,
    input  logic                m_ready,
    output sric_pkg::sric_rsp_t m_payload
);

    import sric_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int DW = KEY_W + VAL_W;

    logic            rsp_valid;
    logic            rsp_ready;
    sric_rsp_t       rsp;
    logic            wr_en;
    logic [AW-1:0]   wr_addr;
    logic [DW-1:0]   wr_data;
    logic            rd_en;
    logic [AW-1:0]   rd_addr;
    logic [DW-1:0]   rd_data;

    logic            m_valid_reg, m_valid_next;
    sric_rsp_t       m_payload_reg, m_payload_next;

    sric_ram #(
        .DEPTH (DEPTH),
        .WIDTH (DW),
        .AW    (AW)
    ) u_ram (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    sric_ctrl #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .req_valid (s_valid),
        .req_ready (s_ready),
        .req       (s_payload),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp),
        .wr_en     (wr_en),
        .wr_addr   (wr_addr),
        .wr_data   (wr_data),
        .rd_en     (rd_en),
        .rd_addr   (rd_addr),
        .rd_data   (rd_data)
    );

    // Output register: load when empty or being drained
    assign rsp_ready = !m_valid_reg || m_ready;

    always_comb begin
        m_valid_next   = m_valid_reg;
        m_payload_next = m_payload_reg;
        if (rsp_ready) begin
            m_valid_next = rsp_valid;
            if (rsp_valid) begin
                m_payload_next = rsp;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_payload_reg <= m_payload_next;
    end

    assign m_valid   = m_valid_reg;
    assign m_payload = m_payload_reg;

    // A miss always reports a zero value
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_payload.found |-> m_payload.found_value == '0)
        else $error("miss response carries a nonzero value");

    // A search holds off further requests while it runs
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && (s_payload.cmd == CMD_SEARCH) |=> !s_ready)
        else $error("request taken during a search");

    // A finished search result is not dropped while the output is blocked
    assert property (@(posedge aclk) disable iff (!aresetn)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
        else $error("search result lost while output stalled");

endmodule

[rtl/sric_ram.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sric_ram
// Simple dual-port synchronous RAM: one write port, one read port with the
// read data registered.
// ----------------------------------------------------------------------------
module sric_ram #(
    parameter int DEPTH = 256,
    parameter int WIDTH = 128,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic             aclk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // Write port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read port
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

[rtl/sric_ctrl.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sric_ctrl
// Ring pointers and the search sequencer: appends write one entry, searches
// run a binary search over the front run and then, if the ring has wrapped,
// the back run.
// ----------------------------------------------------------------------------
module sric_ctrl #(
    parameter int DEPTH = 256,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    // Request side
    input  logic                           req_valid,
    output logic                           req_ready,
    input  sric_pkg::sric_req_t            req,
    // Response side
    output logic                           rsp_valid,
    input  logic                           rsp_ready,
    output sric_pkg::sric_rsp_t            rsp,
    // RAM port
    output logic                           wr_en,
    output logic [AW-1:0]                  wr_addr,
    output logic [sric_pkg::KEY_W+sric_pkg::VAL_W-1:0] wr_data,
    output logic                           rd_en,
    output logic [AW-1:0]                  rd_addr,
    input  logic [sric_pkg::KEY_W+sric_pkg::VAL_W-1:0] rd_data
);

    import sric_pkg::*;

    localparam int CW = AW + 1;
    localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);
    localparam logic [AW-1:0] LAST_C  = AW'(DEPTH - 1);

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_ISSUE = 4'b0010,
        ST_CMP   = 4'b0100,
        ST_DONE  = 4'b1000
    } state_t;

    state_t                  state_reg, state_next;
    logic [CW-1:0]           fill_reg, fill_next;
    logic [AW-1:0]           wp_reg, wp_next;
    logic [CW-1:0]           lo_reg, lo_next;
    logic [CW-1:0]           hi_reg, hi_next;
    logic [CW-1:0]           base_reg, base_next;
    logic [CW-1:0]           mid_reg, mid_next;
    logic                    second_reg, second_next;
    logic [CW-1:0]           back_base_reg, back_base_next;
    logic [CW-1:0]           back_cnt_reg, back_cnt_next;
    logic signed [KEY_W-1:0] key_reg, key_next;
    logic                    found_reg, found_next;
    logic signed [VAL_W-1:0] value_reg, value_next;

    logic                    full;
    logic                    accept;
    logic [CW-1:0]           mid;
    logic [CW-1:0]           probe_sum;
    logic signed [KEY_W-1:0] rd_key;
    logic signed [VAL_W-1:0] rd_value;

    assign full      = (fill_reg == DEPTH_C);
    assign req_ready = (state_reg == ST_IDLE);
    assign accept    = req_valid && req_ready;
    assign mid       = lo_reg + ((hi_reg - lo_reg) >> 1);
    assign probe_sum = base_reg + mid;
    assign rd_key    = rd_data[KEY_W+VAL_W-1:VAL_W];
    assign rd_value  = rd_data[VAL_W-1:0];

    // Append write: fill in order, then overwrite the oldest entry
    assign wr_en   = accept && (req.cmd == CMD_APPEND);
    assign wr_addr = full ? wp_reg : fill_reg[AW-1:0];
    assign wr_data = {req.key, req.entry_value};

    // Probe read
    assign rd_en   = (state_reg == ST_ISSUE) && (lo_reg != hi_reg);
    assign rd_addr = probe_sum[AW-1:0];

    assign rsp_valid         = (state_reg == ST_DONE);
    assign rsp.found         = found_reg;
    assign rsp.found_value   = value_reg;

    // Sequencer
    always_comb begin
        state_next     = state_reg;
        fill_next      = fill_reg;
        wp_next        = wp_reg;
        lo_next        = lo_reg;
        hi_next        = hi_reg;
        base_next      = base_reg;
        mid_next       = mid_reg;
        second_next    = second_reg;
        back_base_next = back_base_reg;
        back_cnt_next  = back_cnt_reg;
        key_next       = key_reg;
        found_next     = found_reg;
        value_next     = value_reg;
        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    if (req.cmd == CMD_APPEND) begin
                        if (full) begin
                            wp_next = (wp_reg == LAST_C) ? '0 : wp_reg + 1'b1;
                        end else begin
                            fill_next = fill_reg + 1'b1;
                        end
                    end else begin
                        // Set up the front run; the back run follows if the ring wrapped
                        key_next       = req.key;
                        lo_next        = '0;
                        base_next      = '0;
                        back_base_next = {1'b0, wp_reg};
                        back_cnt_next  = DEPTH_C - {1'b0, wp_reg};
                        second_next    = full && (wp_reg != '0);
                        if (full) begin
                            hi_next = (wp_reg != '0) ? {1'b0, wp_reg} : DEPTH_C;
                        end else begin
                            hi_next = fill_reg;
                        end
                        state_next = ST_ISSUE;
                    end
                end
            end
            ST_ISSUE: begin
                if (lo_reg == hi_reg) begin
                    if (second_reg) begin
                        // Front run exhausted: move to the back run
                        second_next = 1'b0;
                        lo_next     = '0;
                        hi_next     = back_cnt_reg;
                        base_next   = back_base_reg;
                    end else begin
                        found_next = 1'b0;
                        value_next = '0;
                        state_next = ST_DONE;
                    end
                end else begin
                    mid_next   = mid;
                    state_next = ST_CMP;
                end
            end
            ST_CMP: begin
                if (rd_key == key_reg) begin
                    found_next = 1'b1;
                    value_next = rd_value;
                    state_next = ST_DONE;
                end else begin
                    if (key_reg < rd_key) begin
                        hi_next = mid_reg;
                    end else begin
                        lo_next = mid_reg + 1'b1;
                    end
                    state_next = ST_ISSUE;
                end
            end
            ST_DONE: begin
                if (rsp_ready) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= ST_IDLE;
            fill_reg   <= '0;
            wp_reg     <= '0;
            second_reg <= 1'b0;
        end else begin
            state_reg  <= state_next;
            fill_reg   <= fill_next;
            wp_reg     <= wp_next;
            second_reg <= second_next;
        end
    end

    // Search datapath
    always_ff @(posedge aclk) begin
        lo_reg        <= lo_next;
        hi_reg        <= hi_next;
        base_reg      <= base_next;
        mid_reg       <= mid_next;
        back_base_reg <= back_base_next;
        back_cnt_reg  <= back_cnt_next;
        key_reg       <= key_next;
        found_reg     <= found_next;
        value_reg     <= value_next;
    end

endmodule

[tb/sorted_ring_index_cache_core_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_ring_index_cache_core_tb
// Self-checking bench for the sorted ring index cache core.
// ----------------------------------------------------------------------------
// Append and search requests go in on the s_ channel. An in-bench copy of the
// ring predicts each search response, and the responses on the m_ channel are
// checked in order. The bench covers a directed pass over the edge keys, a
// fill that wraps the ring, a long random mix of ordered, duplicate and stray
// keys, a long hold on the response side, and a closing stretch without gaps.
// ----------------------------------------------------------------------------
module sorted_ring_index_cache_core_tb;

    import sric_pkg::*;

    localparam int DEPTH        = 256;
    localparam int HOLD_CYCLES  = 400;
    localparam int DRAIN_CYCLES = 60;
    localparam int DRAIN_GUARD  = 20000;
    localparam longint TIMEOUT_NS = 64'd8_000_000;

    localparam logic signed [KEY_W-1:0] KEY_MIN = {1'b1, {(KEY_W-1){1'b0}}};
    localparam logic signed [KEY_W-1:0] KEY_MAX = {1'b0, {(KEY_W-1){1'b1}}};
    localparam logic signed [VAL_W-1:0] VAL_MIN = {1'b1, {(VAL_W-1){1'b0}}};
    localparam logic signed [VAL_W-1:0] VAL_MAX = {1'b0, {(VAL_W-1){1'b1}}};

    logic      aclk      = 1'b0;
    logic      aresetn   = 1'b0;
    logic      s_valid   = 1'b0;
    logic      s_ready;
    sric_req_t s_payload = '0;
    logic      m_valid;
    logic      m_ready   = 1'b0;
    sric_rsp_t m_payload;

    // Shadow copy of the ring
    logic signed [KEY_W-1:0] ring_keys [DEPTH];
    logic signed [VAL_W-1:0] ring_vals [DEPTH];
    int ring_fill = 0;
    int ring_wp   = 0;

    sric_rsp_t expected_lookups [$];

    // Key sequence for ordered appends
    logic signed [KEY_W-1:0] seq_key = '0;

    bit idle_enable   = 1'b1;
    int hold_requests = 0;
    int holds_served  = 0;

    int mismatch_count  = 0;
    int append_count    = 0;
    int search_count    = 0;
    int hit_count       = 0;
    int wrap_count      = 0;
    int responses_seen  = 0;

    sorted_ring_index_cache_core #(
        .DEPTH (DEPTH)
    ) i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_payload (s_payload),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_payload (m_payload)
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    // Print one mismatch line and count it
    task automatic report_mismatch(input string msg);
        $display("MISMATCH @%0t: %s", $realtime, msg);
        mismatch_count++;
    endtask

    // Binary search over slots [base, base + count) with a signed compare
    function automatic bit search_run(input int base, input int count,
                                      input logic signed [KEY_W-1:0] key,
                                      output int slot);
        int lo;
        int hi;
        int mid;
        lo   = 0;
        hi   = count;
        slot = 0;
        while (lo < hi) begin
            mid = lo + (hi - lo) / 2;
            if (ring_keys[base + mid] == key) begin
                slot = base + mid;
                return 1'b1;
            end
            if (key < ring_keys[base + mid]) begin
                hi = mid;
            end else begin
                lo = mid + 1;
            end
        end
        return 1'b0;
    endfunction

    // Apply one accepted request to the shadow ring; queue the search response
    function automatic void predict_cache_request(input sric_req_t req);
        sric_rsp_t rsp;
        bit        hit;
        int        slot;
        if (req.cmd == CMD_APPEND) begin
            append_count++;
            if (ring_fill >= DEPTH) begin
                ring_keys[ring_wp] = req.key;
                ring_vals[ring_wp] = req.entry_value;
                if (ring_wp == DEPTH - 1) begin
                    ring_wp = 0;
                    wrap_count++;
                end else begin
                    ring_wp++;
                end
            end else begin
                ring_keys[ring_fill] = req.key;
                ring_vals[ring_fill] = req.entry_value;
                ring_fill++;
            end
        end else begin
            search_count++;
            if (ring_fill >= DEPTH && ring_wp != 0) begin
                hit = search_run(0, ring_wp, req.key, slot);
                if (!hit) begin
                    hit = search_run(ring_wp, DEPTH - ring_wp, req.key, slot);
                end
            end else begin
                hit = search_run(0, ring_fill, req.key, slot);
            end
            rsp.found       = hit;
            rsp.found_value = hit ? ring_vals[slot] : '0;
            if (hit) begin
                hit_count++;
            end
            expected_lookups.push_back(rsp);
        end
    endfunction

    // Offer one request, hold it until accepted, then predict its effect
    task automatic send_request(input sric_req_t req);
        if (idle_enable && $urandom_range(0, 3) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge aclk);
        end
        s_valid   <= 1'b1;
        s_payload <= req;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        predict_cache_request(req);
    endtask

    task automatic do_append(input logic signed [KEY_W-1:0] key,
                             input logic signed [VAL_W-1:0] value);
        sric_req_t req;
        req.cmd         = CMD_APPEND;
        req.key         = key;
        req.entry_value = value;
        send_request(req);
    endtask

    task automatic do_search(input logic signed [KEY_W-1:0] key);
        sric_req_t req;
        req.cmd         = CMD_SEARCH;
        req.key         = key;
        req.entry_value = {$urandom, $urandom};
        send_request(req);
    endtask

    function automatic logic signed [KEY_W-1:0] random_key();
        return {$urandom, $urandom};
    endfunction

    // Advance the ordered key sequence; restart it when it would overflow
    function automatic logic signed [KEY_W-1:0] next_ordered_key();
        logic signed [KEY_W-1:0] step;
        int r;
        r = $urandom_range(0, 9);
        if (r < 6) begin
            step = KEY_W'($urandom_range(1, 16));
        end else if (r < 9) begin
            step = KEY_W'($urandom_range(1, 1 << 20));
        end else begin
            step = {32'd0, $urandom} << $urandom_range(1, 30);
            if (step == 0) begin
                step = 1;
            end
        end
        if (seq_key > KEY_MAX - step) begin
            seq_key = random_key();
        end else begin
            seq_key = seq_key + step;
        end
        return seq_key;
    endfunction

    // Mostly ordered keys, with the odd duplicate or stray key mixed in
    function automatic logic signed [KEY_W-1:0] pick_append_key();
        int r;
        r = $urandom_range(0, 99);
        if (r < 2) begin
            return random_key();
        end else if (r < 4) begin
            return seq_key;
        end
        if ($urandom_range(0, 299) == 0) begin
            seq_key = random_key();
        end
        return next_ordered_key();
    endfunction

    // Mostly stored keys, then near misses, the extremes and random keys
    function automatic logic signed [KEY_W-1:0] pick_search_key();
        logic signed [KEY_W-1:0] k;
        int r;
        r = $urandom_range(0, 99);
        if (ring_fill > 0 && r < 75) begin
            k = ring_keys[$urandom_range(0, ring_fill - 1)];
            if (r >= 55) begin
                k = (r & 1) ? k + 1 : k - 1;
            end
            return k;
        end
        if (r < 85) begin
            return (r & 1) ? KEY_MAX : KEY_MIN;
        end
        return random_key();
    endfunction

    task automatic random_request(input int search_pct);
        if ($urandom_range(0, 99) < search_pct) begin
            do_search(pick_search_key());
        end else begin
            do_append(pick_append_key(), {$urandom, $urandom});
        end
    endtask

    // Edge keys and values, empty cache, hits, misses, out-of-order keys
    task automatic test_directed();
        do_search('0);
        do_search(KEY_MIN);
        do_search(KEY_MAX);
        do_append(KEY_MIN, VAL_MAX);
        do_search(KEY_MIN);
        do_append(-64'sd1, VAL_MIN);
        do_append('0, '0);
        do_append(64'sd1, -64'sd1);
        do_append(KEY_MAX, 64'h5555_5555_5555_5555);
        do_search(KEY_MAX);
        do_search('0);
        do_search(-64'sd1);
        do_search(64'sd1);
        do_search(64'sd2);
        do_search(KEY_MAX - 1);
        do_search(KEY_MIN + 1);
        // Break the ordering: a duplicate and a key below the run
        do_append(64'sd1, 64'h2AAA_AAAA_AAAA_AAAA);
        do_append(KEY_MIN, 64'sd7);
        do_search(64'sd1);
        do_search(KEY_MIN);
        do_search(KEY_MAX);
    endtask

    // Fill the ring, wrap it, and search around the wrap point
    task automatic test_fill_and_wrap();
        int appended;
        appended = 0;
        seq_key  = random_key() >>> 2;
        while (appended < DEPTH + 80) begin
            do_append(next_ordered_key(), {$urandom, $urandom});
            appended++;
            if (ring_fill == DEPTH && ring_wp == 0) begin
                do_search(pick_search_key());
                do_search(ring_keys[DEPTH - 1]);
            end else if ($urandom_range(0, 2) == 0) begin
                do_search(pick_search_key());
            end
        end
    endtask

    task automatic test_random_mix(input int count);
        repeat (count) random_request(45);
    endtask

    // Hold the response side while searches keep coming, so the core stalls
    task automatic test_response_backpressure();
        hold_requests <= hold_requests + 1;
        repeat (40) do_search(pick_search_key());
    endtask

    task automatic test_no_idle(input int count);
        idle_enable = 1'b0;
        repeat (count) random_request(50);
    endtask

    // Check each response against the oldest expected one; drive m_ready
    initial begin : response_checker
        sric_rsp_t exp;
        int idle_left;
        int hold_left;
        idle_left = 0;
        hold_left = 0;
        forever begin
            @(posedge aclk);
            if (aresetn && m_valid && m_ready) begin
                responses_seen++;
                if (expected_lookups.size() == 0) begin
                    report_mismatch($sformatf("unexpected response found=%0b value=%0d",
                                              m_payload.found, m_payload.found_value));
                end else begin
                    exp = expected_lookups.pop_front();
                    if (m_payload.found !== exp.found) begin
                        report_mismatch($sformatf("response %0d found=%0b, want %0b",
                                                  responses_seen, m_payload.found,
                                                  exp.found));
                    end
                    if (m_payload.found_value !== exp.found_value) begin
                        report_mismatch($sformatf("response %0d value=%0d, want %0d",
                                                  responses_seen, m_payload.found_value,
                                                  exp.found_value));
                    end
                end
            end
            if (holds_served != hold_requests) begin
                holds_served++;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else if (idle_left > 0) begin
                idle_left--;
                m_ready <= 1'b0;
            end else if (idle_enable && $urandom_range(0, 5) == 0) begin
                idle_left = $urandom_range(1, 4) - 1;
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    // Stop a hung run
    initial begin
        #(TIMEOUT_NS);
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial begin : main_sequence
        int guard;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_directed();
        test_fill_and_wrap();
        test_random_mix(800);
        test_response_backpressure();
        test_random_mix(20);
        test_no_idle(150);

        // Drop valid and wait for outstanding responses
        s_valid <= 1'b0;
        guard = 0;
        while (expected_lookups.size() != 0 && guard < DRAIN_GUARD) begin
            @(posedge aclk);
            guard++;
        end
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (expected_lookups.size() != 0) begin
            report_mismatch($sformatf("%0d search responses never arrived",
                                      expected_lookups.size()));
        end

        $display("Run covered %0d appends with %0d ring wraps and %0d searches (%0d hits).",
                 append_count, wrap_count, search_count, hit_count);
        $display("Responses checked: %0d, mismatches: %0d.", responses_seen, mismatch_count);
        if (mismatch_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
